@@ design/mps_pkg.sv @@
// ============================================================================
// mps_pkg: shared types and constants for the matrix prime scanner
// Field widths, matrix order, and the controller/datapath command and status.
// ============================================================================
package mps_pkg;

  localparam int ORDER        = 1024;
  localparam int VALUE_W      = 31;
  localparam int POS_W        = 20;
  localparam int RC_W         = 10;
  localparam int DIV_W        = 16;   // odd divisor, ceil(sqrt(2^31)) + 2 fits
  localparam int SQ_W         = 32;   // divisor squared
  localparam int REM_W        = DIV_W + 1;
  localparam int DIGIT_W      = 4;    // dividend bits folded in per cycle
  localparam int SHIFT_W      = 32;   // value padded to whole digits
  localparam int DIGITS       = SHIFT_W / DIGIT_W;
  localparam int DIGIT_CNT_W  = $clog2(DIGITS);

  localparam logic [DIV_W-1:0] FIRST_DIVISOR = DIV_W'(3);
  localparam logic [DIV_W-1:0] DIVISOR_STEP  = DIV_W'(2);
  localparam logic [SQ_W-1:0]  FIRST_SQUARE  = SQ_W'(9);
  localparam logic [VALUE_W-1:0] SMALLEST_PRIME = VALUE_W'(2);

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture a new item
    logic init_div;    // divisor := 3, square := 9
    logic start_div;   // clear remainder, load dividend shifter
    logic div_step;    // fold in one digit of the dividend
    logic advance;     // next odd divisor
    logic finish;      // register the result and strobe it
    logic prime;       // verdict that goes with finish
  } mps_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic below_two;
    logic is_two;
    logic even;
    logic square_over;   // divisor squared exceeds value
    logic last_digit;
    logic rem_zero;
  } mps_stat_t;

endpackage

@@ design/matrix_prime_scanner_top.sv @@
// ============================================================================
// matrix_prime_scanner_top: trial division primality test of matrix elements
// Tests each element, reports prime flag, row, column, value and last mark.
// ============================================================================
// Raise start with an item while busy is low; the item is taken at that edge
// and busy stays high until the verdict is known. Exactly one result follows
// per item, held on the result ports for one cycle with done high; the
// receiver cannot hold it off, so capture it on that cycle. Values below two
// and even values other than two finish in the screening state. Otherwise
// each odd divisor d = 3, 5, 7, ... runs a square bound check, the remainder
// unit at four dividend bits per cycle and a zero check; a 31-bit prime near
// 2^31 tries about 23170 divisors, and the remainder unit takes most of the
// time. The next item may be started on the cycle its predecessor's result
// is shown.
// ============================================================================
module matrix_prime_scanner_top
  import mps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] value,
  input  logic [POS_W-1:0]   position,
  input  logic               last,
  output logic               done,
  output logic               is_prime,
  output logic [RC_W-1:0]    row,
  output logic [RC_W-1:0]    column,
  output logic [VALUE_W-1:0] tested_value,
  output logic               block_end
);

  mps_cmd_t  cmd;
  mps_stat_t stat;

  // sequencer: decide screening, divisor walk and the verdict
  mps_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // hold the item, track divisor and its square, run the remainder unit
  mps_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .value        (value),
    .position     (position),
    .last         (last),
    .done         (done),
    .is_prime     (is_prime),
    .row          (row),
    .column       (column),
    .tested_value (tested_value),
    .block_end    (block_end)
  );

endmodule

@@ design/mps_datapath.sv @@
// ============================================================================
// mps_datapath: item registers, divisor/square tracking and remainder unit
// Folds the dividend into the remainder four bits per cycle.
// ============================================================================
module mps_datapath
  import mps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  mps_cmd_t           cmd,
  output mps_stat_t          stat,
  input  logic [VALUE_W-1:0] value,
  input  logic [POS_W-1:0]   position,
  input  logic               last,
  output logic               done,
  output logic               is_prime,
  output logic [RC_W-1:0]    row,
  output logic [RC_W-1:0]    column,
  output logic [VALUE_W-1:0] tested_value,
  output logic               block_end
);

  localparam logic [POS_W-1:0] ORDER_P = POS_W'(ORDER);

  logic [VALUE_W-1:0]     val;
  logic [POS_W-1:0]       pos;
  logic                   lst;
  logic [DIV_W-1:0]       divisor;
  logic [SQ_W-1:0]        square;
  logic [REM_W-1:0]       rem;
  logic [REM_W-1:0]       rem_next;
  logic [SHIFT_W-1:0]     shifter;
  logic [DIGIT_CNT_W-1:0] digit_cnt;

  // one radix-16 digit: four chained shift/compare/subtract steps
  always_comb begin
    logic [REM_W-1:0] r;
    r = rem;
    for (int i = 0; i < DIGIT_W; i++) begin
      r = {r[REM_W-2:0], shifter[SHIFT_W-1-i]};
      if (r >= {1'b0, divisor}) begin
        r = r - {1'b0, divisor};
      end
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val <= value;
      pos <= position;
      lst <= last;
    end
    if (cmd.init_div) begin
      divisor <= FIRST_DIVISOR;
      square  <= FIRST_SQUARE;
    end else if (cmd.advance) begin
      divisor <= divisor + DIVISOR_STEP;
      square  <= square + {{(SQ_W-DIV_W-2){1'b0}}, divisor, 2'b00} + SQ_W'(4);
    end
    if (cmd.start_div) begin
      rem       <= '0;
      shifter   <= {{(SHIFT_W-VALUE_W){1'b0}}, val};
      digit_cnt <= '0;
    end else if (cmd.div_step) begin
      rem       <= rem_next;
      shifter   <= {shifter[SHIFT_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      digit_cnt <= digit_cnt + 1'b1;
    end
    if (cmd.finish) begin
      is_prime     <= cmd.prime;
      row          <= RC_W'(pos / ORDER_P);
      column       <= RC_W'(pos % ORDER_P);
      tested_value <= val;
      block_end    <= lst;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_comb begin
    stat.below_two   = (val < SMALLEST_PRIME);
    stat.is_two      = (val == SMALLEST_PRIME);
    stat.even        = ~val[0];
    stat.square_over = (square > {{(SQ_W-VALUE_W){1'b0}}, val});
    stat.last_digit  = (digit_cnt == DIGIT_CNT_W'(DIGITS - 1));
    stat.rem_zero    = (rem == '0);
  end

endmodule

@@ design/mps_ctrl.sv @@
// ============================================================================
// mps_ctrl: sequencer for the trial division test
// Screens small and even values, then walks the odd divisors.
// ============================================================================
module mps_ctrl
  import mps_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  mps_stat_t stat,
  output mps_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCREEN = 5'b00010,
    S_TEST   = 5'b00100,
    S_DIVIDE = 5'b01000,
    S_EVAL   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SCREEN;
        end
      end
      S_SCREEN: begin
        priority if (stat.is_two) begin
          cmd.finish = 1'b1;
          cmd.prime  = 1'b1;
          state_next = S_IDLE;
        end else if (stat.below_two || stat.even) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.init_div = 1'b1;
          state_next   = S_TEST;
        end
      end
      S_TEST: begin
        if (stat.square_over) begin
          cmd.finish = 1'b1;
          cmd.prime  = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.start_div = 1'b1;
          state_next    = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (stat.last_digit) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.rem_zero) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_TEST;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ tb/matrix_prime_scanner_top_tb.sv @@
// ============================================================================
// matrix_prime_scanner_top_tb: self-checking bench for the prime scanner
// Sends matrix elements through the start/busy handshake and predicts each
// verdict by trial division. Checks every strobed result field by field,
// in order, against the predicted verdicts.
// ============================================================================
module matrix_prime_scanner_top_tb;
  import mps_pkg::*;

  // Run length: the two slow values near 2^31 (a prime and the square of a
  // prime) take far longer than any other item, and the random part adds
  // less. The limit allows several times the expected run.
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int DRAIN_WAIT  = 20;   // settle time after the last result
  localparam int QUIET_TAIL  = 20;   // items at the end sent with no idling
  localparam int RANDOM_ITEMS = 100;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
    logic               last;
    bit                 drain;   // hold this item until all verdicts are in
  } element_t;

  typedef struct {
    logic               is_prime;
    logic [RC_W-1:0]    row;
    logic [RC_W-1:0]    column;
    logic [VALUE_W-1:0] tested_value;
    logic               block_end;
  } verdict_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [VALUE_W-1:0] value = '0;
  logic [POS_W-1:0]   position = '0;
  logic               last = 1'b0;
  logic               done;
  logic               is_prime;
  logic [RC_W-1:0]    row;
  logic [RC_W-1:0]    column;
  logic [VALUE_W-1:0] tested_value;
  logic               block_end;

  element_t pending_elements[$];
  verdict_t awaited_verdicts[$];
  element_t in_flight;
  int       idle_left = 0;
  int       errors = 0;
  int       verdicts_seen = 0;
  int       cycles = 0;

  matrix_prime_scanner_top u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .value        (value),
    .position     (position),
    .last         (last),
    .done         (done),
    .is_prime     (is_prime),
    .row          (row),
    .column       (column),
    .tested_value (tested_value),
    .block_end    (block_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predict the verdict for one element: trial division by odd divisors
  // while the divisor squared stays within the value.
  function automatic verdict_t scan_element(input element_t e);
    verdict_t        r;
    longint unsigned v;
    longint unsigned d;
    longint unsigned pos;
    longint unsigned ord;
    logic            composite;
    v = e.value;
    pos = e.position;
    ord = (ORDER < 1) ? 1 : ORDER;
    if (v < 2) begin
      composite = 1'b1;
    end else if (v == 2) begin
      composite = 1'b0;
    end else if (v % 2 == 0) begin
      composite = 1'b1;
    end else begin
      composite = 1'b0;
      d = 3;
      while (!composite && d * d <= v) begin
        if (v % d == 0) composite = 1'b1;
        d += 2;
      end
    end
    r.is_prime     = !composite;
    r.row          = RC_W'(pos / ord);
    r.column       = RC_W'(pos % ord);
    r.tested_value = e.value;
    r.block_end    = e.last;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input longint unsigned got,
                             input longint unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                verdicts_seen, name, got, want));
  endtask

  task automatic queue_element(input longint unsigned v, input longint unsigned pos,
                               input bit lst, input bit drn);
    element_t e;
    e.value    = VALUE_W'(v);
    e.position = POS_W'(pos);
    e.last     = lst;
    e.drain    = drn;
    pending_elements.push_back(e);
  endtask

  // Driver: record the prediction at the accepting edge, hold start while
  // busy, otherwise idle out a burst or launch the next pending item.
  always @(posedge clk) begin
    logic accepted;
    logic keep_start;
    if (rst) begin
      start <= 1'b0;
    end else begin
      accepted = start && !busy;
      if (accepted) awaited_verdicts.push_back(scan_element(in_flight));
      keep_start = start && !accepted;
      if (!keep_start) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (pending_elements.size() > 0 &&
                     !(pending_elements[0].drain && awaited_verdicts.size() > 0)) begin
          in_flight = pending_elements.pop_front();
          value    <= in_flight.value;
          position <= in_flight.position;
          last     <= in_flight.last;
          keep_start = 1'b1;
          // Start an idle burst after this item now and then, but not near the end.
          if (pending_elements.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
            idle_left = $urandom_range(1, 7);
        end
      end
      start <= keep_start;
    end
  end

  // Monitor: a result is valid only in the cycle done is high; compare it
  // against the oldest verdict still awaited.
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && done) begin
      if (awaited_verdicts.size() == 0) begin
        report_mismatch($sformatf("result with no item outstanding, value %0d",
                                  tested_value));
      end else begin
        want = awaited_verdicts.pop_front();
        check_field("is_prime", is_prime, want.is_prime);
        check_field("row", row, want.row);
        check_field("column", column, want.column);
        check_field("tested_value", tested_value, want.tested_value);
        check_field("block_end", block_end, want.block_end);
      end
      verdicts_seen++;
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int              kind;
    int              width;
    longint unsigned v;
    longint unsigned pos;

    // Directed part: zero and one, two, small primes and squares of primes,
    // field extremes, and the two slowest cases near the top of the range.
    queue_element(0, 0, 1'b0, 1'b0);
    queue_element(1, 1048575, 1'b1, 1'b0);
    queue_element(2, 1023, 1'b0, 1'b0);
    queue_element(3, 1024, 1'b1, 1'b0);
    queue_element(4, 524288, 1'b0, 1'b0);
    queue_element(9, 1025, 1'b0, 1'b0);
    queue_element(25, 2047, 1'b1, 1'b0);
    queue_element(49, 12345, 1'b0, 1'b0);
    queue_element(15, 699050, 1'b0, 1'b0);
    queue_element(97, 349525, 1'b1, 1'b0);
    queue_element(65537, 1048575, 1'b0, 1'b0);
    queue_element(1073741824, 0, 1'b0, 1'b0);
    queue_element(2147483646, 1048575, 1'b1, 1'b0);
    queue_element(2147483645, 512, 1'b0, 1'b0);
    queue_element(2147483647, 1048575, 1'b1, 1'b0);
    queue_element(2147117569, 1047552, 1'b0, 1'b0);   // square of a prime near the top
    queue_element(1431655765, 1, 1'b1, 1'b0);

    // Random part: mostly small values so each scan stays short; wide even
    // values and multiples of three reach the upper value bits cheaply.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        width = $urandom_range(2, 18);
        v = $urandom & ((32'd1 << width) - 1);
      end else if (kind == 7) begin
        v = {$urandom_range(0, 32'h3FFF_FFFF), 1'b0};
      end else if (kind == 8) begin
        v = 3 * longint'($urandom_range(0, 715827882));
      end else begin
        v = $urandom_range(0, 4095) | 1;
      end
      pos = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 1048575 : 0)
                                        : ($urandom & 20'hFFFFF);
      // Drain fully before the first random item and now and then after.
      queue_element(v, pos, $urandom_range(0, 1),
                    (i == 0) || ($urandom_range(0, 19) == 0));
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Wait for every item to be taken, then for every verdict, then settle.
    while (pending_elements.size() > 0 || start) @(posedge clk);
    while (awaited_verdicts.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
